>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define BFFA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define BFFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

>>> hw/rtl/bffa_pkg.sv
// Shared constants, codes and types for the bitmap first-free allocator.
// No dependencies; imported by every allocator module.
package bffa_pkg;

   localparam int MAP_BITS_DEFAULT  = 8192;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int CFG_W      = 14;
   localparam int NUM_W      = 14;
   localparam int WIDX_W     = 8;
   localparam int DATA_W     = 32;
   localparam int COUNT_W    = 16;
   localparam int OPCODE_W   = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0] CFG_RESET = 14'd8192;

   localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   localparam logic [1:0] REG_INODE_MAP_SIZE   = 2'd0;
   localparam logic [1:0] REG_BLOCK_MAP_SIZE   = 2'd1;
   localparam logic [1:0] REG_INODE_FREE_START = 2'd2;
   localparam logic [1:0] REG_BLOCK_FREE_START = 2'd3;

   // Register contents and counter load strobes handed to the sequencer.
   typedef struct packed {
      logic [CFG_W-1:0] inode_size;
      logic [CFG_W-1:0] block_size;
      logic             inode_load;
      logic             block_load;
      logic [CFG_W-1:0] inode_start;
      logic [CFG_W-1:0] block_start;
   } cfg_type;

endpackage

>>> hw/rtl/bffa_bitmap_ram.sv
// Single-port bitmap memory with a registered read port.
// Depends on bffa_pkg for the default word width and depth.
module bffa_bitmap_ram
   import bffa_pkg::*;
#(
   parameter int WIDTH = WORD_BITS_DEFAULT,
   parameter int DEPTH = MAP_BITS_DEFAULT / WORD_BITS_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem[addr] <= wdata;
      end
      if (en && !we) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/bffa_csr.sv
// Configuration register file behind the APB-style port.
// Depends on bffa_pkg for register indexes, widths and cfg_type.
module bffa_csr
   import bffa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [CFG_W-1:0] inode_size_ff, inode_size_in;
   logic [CFG_W-1:0] block_size_ff, block_size_in;
   logic [CFG_W-1:0] inode_start_ff, inode_start_in;
   logic [CFG_W-1:0] block_start_ff, block_start_in;
   logic             wr_strobe;
   logic [1:0]       reg_idx;
   logic [CFG_W-1:0] wr_value;
   logic [CFG_W-1:0] rd_value;

   assign csr_pready = 1'b1;
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_value   = csr_pwdata[CFG_W-1:0];

   always_comb begin
      inode_size_in  = inode_size_ff;
      block_size_in  = block_size_ff;
      inode_start_in = inode_start_ff;
      block_start_in = block_start_ff;
      if (wr_strobe) begin
         unique case (reg_idx)
            REG_INODE_MAP_SIZE:   inode_size_in  = wr_value;
            REG_BLOCK_MAP_SIZE:   block_size_in  = wr_value;
            REG_INODE_FREE_START: inode_start_in = wr_value;
            REG_BLOCK_FREE_START: block_start_in = wr_value;
            default:              inode_size_in  = inode_size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inode_size_ff  <= CFG_RESET;
         block_size_ff  <= CFG_RESET;
         inode_start_ff <= CFG_RESET;
         block_start_ff <= CFG_RESET;
      end else begin
         inode_size_ff  <= inode_size_in;
         block_size_ff  <= block_size_in;
         inode_start_ff <= inode_start_in;
         block_start_ff <= block_start_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_INODE_MAP_SIZE:   rd_value = inode_size_ff;
         REG_BLOCK_MAP_SIZE:   rd_value = block_size_ff;
         REG_INODE_FREE_START: rd_value = inode_start_ff;
         REG_BLOCK_FREE_START: rd_value = block_start_ff;
         default:              rd_value = '0;
      endcase
   end

   assign csr_prdata = CSR_DATA_W'(rd_value);

   // Writing a free-start register also reloads the matching counter.
   assign cfg.inode_size  = inode_size_ff;
   assign cfg.block_size  = block_size_ff;
   assign cfg.inode_load  = wr_strobe && (reg_idx == REG_INODE_FREE_START);
   assign cfg.block_load  = wr_strobe && (reg_idx == REG_BLOCK_FREE_START);
   assign cfg.inode_start = wr_value;
   assign cfg.block_start = wr_value;

endmodule

>>> hw/rtl/bffa_ctrl.sv
// Sequencer: clearing pass, word scan, read-modify-write, counters and result register.
// Depends on bffa_pkg and assert_macros.svh; drives both bffa_bitmap_ram instances.
`include "assert_macros.svh"

module bffa_ctrl
   import bffa_pkg::*;
#(
   parameter int MAP_BITS  = MAP_BITS_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT,
   localparam int MAP_WORDS = MAP_BITS / WORD_BITS,
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [OPCODE_W-1:0]  req_opcode,
   input  logic                 req_map_select,
   input  logic [NUM_W-1:0]     req_item_number,
   input  logic [WIDX_W-1:0]    req_word_index,
   input  logic [DATA_W-1:0]    req_word_data,
   input  cfg_type              cfg,
   output logic [1:0]           mem_en,
   output logic [1:0]           mem_we,
   output logic [ADDR_W-1:0]    mem_addr,
   output logic [WORD_BITS-1:0] mem_wdata,
   input  logic [WORD_BITS-1:0] rdata_inode,
   input  logic [WORD_BITS-1:0] rdata_block,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [NUM_W-1:0]     rsp_number,
   output logic [COUNT_W-1:0]   rsp_count
);

   localparam int SZ_W  = (CFG_W > $clog2(MAP_BITS + 1)) ? CFG_W : $clog2(MAP_BITS + 1);
   localparam int BIT_W = $clog2(WORD_BITS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_RMW,
      ST_WRITE,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic [OPCODE_W-1:0]   op_ff, op_in;
   logic                  sel_ff, sel_in;
   logic [ADDR_W-1:0]     last_word_ff, last_word_in;
   logic [BIT_W-1:0]      tail_ff, tail_in;
   logic [BIT_W-1:0]      bitpos_ff, bitpos_in;
   logic [ADDR_W-1:0]     wr_addr_ff, wr_addr_in;
   logic [WORD_BITS-1:0]  wr_data_ff, wr_data_in;
   logic [ADDR_W-1:0]     issue_addr_ff, issue_addr_in;
   logic                  issue_done_ff, issue_done_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0]     eval_addr_ff, eval_addr_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [NUM_W-1:0]      number_ff, number_in;
   logic [COUNT_W-1:0]    inode_cnt_ff, inode_cnt_in;
   logic [COUNT_W-1:0]    block_cnt_ff, block_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [NUM_W-1:0]      rsp_number_ff, rsp_number_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic [WORD_BITS-1:0]  rdata;
   logic [WORD_BITS-1:0]  valid_mask;
   logic [WORD_BITS-1:0]  free_bits;
   logic [WORD_BITS-1:0]  low_free;
   logic [BIT_W-1:0]      low_idx;
   logic                  found;
   logic [SZ_W-1:0]       granted;
   logic [CFG_W-1:0]      req_size_cfg;
   logic [SZ_W-1:0]       req_size;
   logic [SZ_W-1:0]       req_last;
   logic [SZ_W-1:0]       req_num_ext;
   logic [SZ_W-1:0]       req_idx;
   logic                  range_bad;
   logic                  accept;
   logic                  out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // A size above the map's capacity behaves as the capacity.
   assign req_size_cfg = req_map_select ? cfg.block_size : cfg.inode_size;
   assign req_size     = (SZ_W'(req_size_cfg) > SZ_W'(MAP_BITS)) ? SZ_W'(MAP_BITS)
                                                                 : SZ_W'(req_size_cfg);
   assign req_last     = req_size - SZ_W'(1);
   assign req_num_ext  = SZ_W'(req_item_number);
   assign req_idx      = req_num_ext - SZ_W'(1);
   assign range_bad    = (req_item_number == '0) || (req_num_ext > req_size);

   assign rdata = sel_ff ? rdata_block : rdata_inode;

   // Bits beyond the configured size count as taken; only the last word is trimmed.
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         valid_mask[b] = (eval_addr_ff != last_word_ff) || (BIT_W'(b) <= tail_ff);
      end
   end

   assign free_bits = ~rdata & valid_mask;
   assign low_free  = free_bits & (~free_bits + WORD_BITS'(1));
   assign found     = |free_bits;

   always_comb begin
      low_idx = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (low_free[b]) begin
            low_idx = low_idx | BIT_W'(b);
         end
      end
   end

   assign granted = SZ_W'({eval_addr_ff, low_idx}) + SZ_W'(1);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      op_in         = op_ff;
      sel_in        = sel_ff;
      last_word_in  = last_word_ff;
      tail_in       = tail_ff;
      bitpos_in     = bitpos_ff;
      wr_addr_in    = wr_addr_ff;
      wr_data_in    = wr_data_ff;
      issue_addr_in = issue_addr_ff;
      issue_done_in = issue_done_ff;
      rd_valid_in   = 1'b0;
      eval_addr_in  = eval_addr_ff;
      status_in     = status_ff;
      number_in     = number_ff;
      inode_cnt_in  = inode_cnt_ff;
      block_cnt_in  = block_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_number_in = rsp_number_ff;
      rsp_count_in  = rsp_count_ff;
      mem_en        = 2'b00;
      mem_we        = 2'b00;
      mem_addr      = wr_addr_ff;
      mem_wdata     = wr_data_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_en    = 2'b11;
            mem_we    = 2'b11;
            mem_addr  = clr_addr_ff;
            mem_wdata = '0;
            if (clr_addr_ff == ADDR_W'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_opcode;
               sel_in    = req_map_select;
               status_in = STATUS_OK;
               number_in = '0;
               unique case (req_opcode)
                  OP_ALLOC: begin
                     if (req_size == '0) begin
                        status_in = STATUS_FULL;
                        state_in  = ST_FINISH;
                     end else begin
                        last_word_in  = req_last[BIT_W +: ADDR_W];
                        tail_in       = req_last[BIT_W-1:0];
                        issue_addr_in = '0;
                        issue_done_in = 1'b0;
                        state_in      = ST_SCAN;
                     end
                  end
                  OP_FREE: begin
                     if (range_bad) begin
                        status_in = STATUS_RANGE;
                        state_in  = ST_FINISH;
                     end else begin
                        mem_en[req_map_select] = 1'b1;
                        mem_addr   = req_idx[BIT_W +: ADDR_W];
                        wr_addr_in = req_idx[BIT_W +: ADDR_W];
                        bitpos_in  = req_idx[BIT_W-1:0];
                        state_in   = ST_RMW;
                     end
                  end
                  OP_LOAD: begin
                     if (32'(req_word_index) < 32'(MAP_WORDS)) begin
                        wr_addr_in = ADDR_W'(req_word_index);
                        wr_data_in = WORD_BITS'(req_word_data);
                        state_in   = ST_WRITE;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Reads go out one word a cycle; each word is judged when its data returns.
            if (!issue_done_ff) begin
               mem_en[sel_ff] = 1'b1;
               mem_addr       = issue_addr_ff;
               rd_valid_in    = 1'b1;
               eval_addr_in   = issue_addr_ff;
               if (issue_addr_ff == last_word_ff) begin
                  issue_done_in = 1'b1;
               end else begin
                  issue_addr_in = issue_addr_ff + ADDR_W'(1);
               end
            end
            if (rd_valid_ff) begin
               if (found) begin
                  wr_addr_in = eval_addr_ff;
                  wr_data_in = rdata | low_free;
                  number_in  = granted[NUM_W-1:0];
                  state_in   = ST_WRITE;
               end else if (eval_addr_ff == last_word_ff) begin
                  status_in = STATUS_FULL;
                  state_in  = ST_FINISH;
               end
            end
         end
         ST_RMW: begin
            wr_data_in = rdata & ~(WORD_BITS'(1) << bitpos_ff);
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            mem_en[sel_ff] = 1'b1;
            mem_we[sel_ff] = 1'b1;
            mem_addr       = wr_addr_ff;
            mem_wdata      = wr_data_ff;
            if (op_ff == OP_ALLOC) begin
               if (sel_ff) begin
                  block_cnt_in = block_cnt_ff - COUNT_W'(1);
               end else begin
                  inode_cnt_in = inode_cnt_ff - COUNT_W'(1);
               end
            end else if (op_ff == OP_FREE) begin
               if (sel_ff) begin
                  block_cnt_in = block_cnt_ff + COUNT_W'(1);
               end else begin
                  inode_cnt_in = inode_cnt_ff + COUNT_W'(1);
               end
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_number_in = number_ff;
               rsp_count_in  = sel_ff ? block_cnt_ff : inode_cnt_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg.inode_load) begin
         inode_cnt_in = COUNT_W'(cfg.inode_start);
      end
      if (cfg.block_load) begin
         block_cnt_in = COUNT_W'(cfg.block_start);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         issue_done_ff <= 1'b1;
         rd_valid_ff   <= 1'b0;
         inode_cnt_ff  <= COUNT_W'(CFG_RESET);
         block_cnt_ff  <= COUNT_W'(CFG_RESET);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         issue_done_ff <= issue_done_in;
         rd_valid_ff   <= rd_valid_in;
         inode_cnt_ff  <= inode_cnt_in;
         block_cnt_ff  <= block_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      sel_ff        <= sel_in;
      last_word_ff  <= last_word_in;
      tail_ff       <= tail_in;
      bitpos_ff     <= bitpos_in;
      wr_addr_ff    <= wr_addr_in;
      wr_data_ff    <= wr_data_in;
      issue_addr_ff <= issue_addr_in;
      eval_addr_ff  <= eval_addr_in;
      status_ff     <= status_in;
      number_ff     <= number_in;
      rsp_status_ff <= rsp_status_in;
      rsp_number_ff <= rsp_number_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_number = rsp_number_ff;
   assign rsp_count  = rsp_count_ff;

   `BFFA_ASSERT_NEXT(a_grant_lowers_inode_count, clock, reset, state_ff == ST_WRITE && op_ff == OP_ALLOC && !sel_ff && !cfg.inode_load, inode_cnt_ff == $past(inode_cnt_ff) - 16'd1)
   `BFFA_ASSERT_IMPL(a_one_map_written, clock, reset, state_ff != ST_CLEAR, !(mem_we[0] && mem_we[1]))
   `BFFA_ASSERT_IMPL(a_grant_nonzero, clock, reset, state_ff == ST_WRITE && op_ff == OP_ALLOC, number_ff != '0)
   `BFFA_ASSERT_IMPL(a_quiet_while_clearing, clock, reset, state_ff == ST_CLEAR, !rsp_valid_ff && !req_tready)

endmodule

>>> hw/rtl/bitmap_first_free_allocator_core.sv
// Inode and data-block bitmap allocator: each map is a single-port RAM of MAP_BITS/WORD_BITS
// words (256 at the defaults), swept clear after reset while req_tready stays low. Items are
// handled one at a time. A load writes its word and then gives its result; a free reads,
// modifies and writes back its word; an out-of-range or unused operation answers without a
// map access. An allocate reads one word per cycle from the map's single RAM port up to the
// first one with a clear bit, then writes that word back with the bit set. A full map reads
// all ceil(size / WORD_BITS) words before it answers, and a zero size answers with no read.
// A registered result stage lets the next item be accepted while a result waits.
// Depends on bffa_pkg, bffa_csr, bffa_ctrl and bffa_bitmap_ram.
module bitmap_first_free_allocator_core
   import bffa_pkg::*;
#(
   parameter int MAP_BITS  = MAP_BITS_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // item_number [13:0], word_index [21:14], word_data [53:22], zero fill [55:54]
   input  logic [55:0]           req_tdata,
   // opcode [1:0], map_select [2]
   input  logic [2:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status [1:0], allocated_number [15:2], free_count [31:16]
   output logic [31:0]           rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int MAP_WORDS = MAP_BITS / WORD_BITS;
   localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   cfg_type              cfg;
   logic [1:0]           mem_en;
   logic [1:0]           mem_we;
   logic [ADDR_W-1:0]    mem_addr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [WORD_BITS-1:0] rdata_inode;
   logic [WORD_BITS-1:0] rdata_block;
   logic [STATUS_W-1:0]  rsp_status;
   logic [NUM_W-1:0]     rsp_number;
   logic [COUNT_W-1:0]   rsp_count;

   bffa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bffa_ctrl #(
      .MAP_BITS  (MAP_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_opcode      (req_tuser[1:0]),
      .req_map_select  (req_tuser[2]),
      .req_item_number (req_tdata[13:0]),
      .req_word_index  (req_tdata[21:14]),
      .req_word_data   (req_tdata[53:22]),
      .cfg             (cfg),
      .mem_en          (mem_en),
      .mem_we          (mem_we),
      .mem_addr        (mem_addr),
      .mem_wdata       (mem_wdata),
      .rdata_inode     (rdata_inode),
      .rdata_block     (rdata_block),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_number      (rsp_number),
      .rsp_count       (rsp_count)
   );

   bffa_bitmap_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_inode_map (
      .clock (clock),
      .en    (mem_en[0]),
      .we    (mem_we[0]),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (rdata_inode)
   );

   bffa_bitmap_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_block_map (
      .clock (clock),
      .en    (mem_en[1]),
      .we    (mem_we[1]),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (rdata_block)
   );

   assign rsp_tdata = {rsp_count, rsp_number, rsp_status};

endmodule
